FILE: rtl/core/lgs_pkg.sv
package lgs_pkg;

	// defaults for the board size
	localparam int DEF_MAX_ROWS = 32;
	localparam int DEF_MAX_COLS = 64;

	// row counters hold any value up to the largest board depth
	localparam int NR_W = 9;

	// field and register widths
	localparam int ROW_W     = 5;
	localparam int COL_W     = 6;
	localparam int NC_W      = 7;
	localparam int NRI_W     = 6;
	localparam int CFG_IW    = 8;
	localparam int CFG_DW    = 7;
	localparam int IN_DW     = 16;
	localparam int OUT_BITS  = 64;
	localparam int OUT_DW    = 72;

	localparam logic [NRI_W-1:0] ROWS_RESET = 6'd20;
	localparam logic [NC_W-1:0]  COLS_RESET = 7'd40;

	localparam logic [CFG_IW-1:0] REG_ROWS = 8'd0;
	localparam logic [CFG_IW-1:0] REG_COLS = 8'd1;

	// neighbour counts of the b3/s23 rule
	localparam logic [3:0] NB_BIRTH   = 4'd3;
	localparam logic [3:0] NB_SURVIVE = 4'd2;

	typedef enum logic [1:0] {
		MODE_ADVANCE = 2'd0,
		MODE_TOGGLE  = 2'd1,
		MODE_CLEAR   = 2'd2,
		MODE_READ    = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEN,
		ST_GEN_END,
		ST_RD,
		ST_RD_DATA,
		ST_OUT
	} state_t;

endpackage

FILE: rtl/core/lgs_ram.sv
module lgs_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/core/lgs_rule.sv
module lgs_rule #(
	parameter int COLS = 64
) (
	input  logic [COLS-1:0] above,
	input  logic [COLS-1:0] here,
	input  logic [COLS-1:0] below,
	input  logic [COLS-1:0] cmask,
	output logic [COLS-1:0] next_row
);

	logic [COLS+1:0] a_p, h_p, b_p;
	logic [3:0]      cnt [COLS];

	// pad with dead cells at both edges
	assign a_p = {1'b0, above, 1'b0};
	assign h_p = {1'b0, here, 1'b0};
	assign b_p = {1'b0, below, 1'b0};

	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			cnt[c] = 4'(a_p[c]) + 4'(a_p[c+1]) + 4'(a_p[c+2])
				+ 4'(h_p[c]) + 4'(h_p[c+2])
				+ 4'(b_p[c]) + 4'(b_p[c+1]) + 4'(b_p[c+2]);
			next_row[c] = cmask[c] & ((cnt[c] == lgs_pkg::NB_BIRTH)
				|| ((cnt[c] == lgs_pkg::NB_SURVIVE) && here[c]));
		end
	end

endmodule

FILE: rtl/core/life_grid_generation_step_core.sv
// channel  | direction | fields (lsb first)                  | handshake
// s_*      | in        | mode[1:0] row[6:2] col[12:7]        | s_tvalid/s_tready
// m_*      | out       | row_bits[63:0] cell_res[64]         | m_tvalid/m_tready
// cfg_*    | in        | cfg_index selects, cfg_data value    | cfg_valid/cfg_ready
//
// one request at a time; read, toggle and clear go through ST_RD, ST_RD_DATA and ST_OUT
// an advance first sweeps every row through the single read port of the board memory
// (one row per cycle), then reads the addressed row through the same states
// arst_n and a clear request both clear the row valid bits, so the board reads dead after reset and clear
// a result held by m_tready low does not block the next accept; that request waits
// for the output register only at its end
module life_grid_generation_step_core #(
	parameter int MAX_ROWS = lgs_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = lgs_pkg::DEF_MAX_COLS
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [lgs_pkg::IN_DW-1:0]    s_tdata,  // mode[1:0], row[6:2], col[12:7], zero
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lgs_pkg::OUT_DW-1:0]   m_tdata,  // row_bits[63:0], cell_res[64], zero
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lgs_pkg::CFG_IW-1:0]   cfg_index,
	input  logic [lgs_pkg::CFG_DW-1:0]   cfg_data
);

	localparam int RA_W = $clog2(MAX_ROWS);
	localparam int NR_W = lgs_pkg::NR_W;

	lgs_pkg::state_t state_q, state_d;

	lgs_pkg::mode_t               mode_q;
	logic [lgs_pkg::ROW_W-1:0]    row_q;
	logic [lgs_pkg::COL_W-1:0]    col_q;
	logic [lgs_pkg::NRI_W-1:0]    rows_q;
	logic [lgs_pkg::NC_W-1:0]     cols_q;

	logic [NR_W-1:0]     gen_cnt_q;
	logic [NR_W-1:0]     rd_row_s1;
	logic                rd_ok_s1;
	logic                gen_go_s1;
	logic [MAX_COLS-1:0] above_q, here_q;
	logic [MAX_ROWS-1:0] valid_q;
	logic [MAX_COLS-1:0] pend_bits_q;
	logic                pend_cell_q;
	logic                m_tvalid_q;
	logic [lgs_pkg::OUT_BITS-1:0] out_bits_q;
	logic                out_cell_q;

	logic [NR_W-1:0]              nr;
	logic [lgs_pkg::NC_W-1:0]     nc;
	logic [MAX_COLS-1:0]          cmask;
	logic [NR_W-1:0]              row_w;
	logic                         row_act, col_act;
	logic                         s_acc;
	lgs_pkg::mode_t               in_mode;

	logic [RA_W-1:0]     raddr, waddr;
	logic                issue_live;
	logic                we;
	logic [MAX_COLS-1:0] wdata, rdata;
	logic [MAX_COLS-1:0] rd_base, gen_view, rule_next, tog_bit, new_row, res_row;
	logic [NR_W-1:0]     wr_idx;
	logic                tog_hit;
	logic [lgs_pkg::OUT_BITS-1:0] res64;
	logic                out_load;

	assign in_mode   = lgs_pkg::mode_t'(s_tdata[1:0]);
	assign s_acc     = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// active area, saturated at the board size
	assign nr = (NR_W'(rows_q) > NR_W'(MAX_ROWS)) ? NR_W'(MAX_ROWS) : NR_W'(rows_q);
	assign nc = (cols_q > lgs_pkg::NC_W'(MAX_COLS)) ? lgs_pkg::NC_W'(MAX_COLS) : cols_q;

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			cmask[c] = lgs_pkg::NC_W'(c) < nc;
		end
	end

	assign row_w   = NR_W'(row_q);
	assign row_act = row_w < nr;
	assign col_act = lgs_pkg::NC_W'(col_q) < nc;

	// read side: the sweep during a generation, otherwise the addressed row
	always_comb begin
		if (state_q == lgs_pkg::ST_GEN) begin
			issue_live = gen_cnt_q < NR_W'(MAX_ROWS);
			raddr      = issue_live ? gen_cnt_q[RA_W-1:0] : '0;
		end else begin
			issue_live = row_act;
			raddr      = row_act ? row_w[RA_W-1:0] : '0;
		end
	end

	lgs_ram #(
		.WIDTH(MAX_COLS),
		.DEPTH(MAX_ROWS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// rows never written since reset or clear read as dead
	assign rd_base  = rd_ok_s1 ? rdata : '0;
	assign gen_view = (rd_row_s1 < nr) ? (rd_base & cmask) : '0;

	lgs_rule #(
		.COLS(MAX_COLS)
	) u_rule (
		.above   (above_q),
		.here    (here_q),
		.below   (gen_view),
		.cmask   (cmask),
		.next_row(rule_next)
	);

	assign wr_idx  = rd_row_s1 - NR_W'(1);
	assign tog_bit = MAX_COLS'(1) << col_q;
	assign tog_hit = (mode_q == lgs_pkg::MODE_TOGGLE) && row_act && col_act;
	assign new_row = rd_base ^ (tog_hit ? tog_bit : '0);
	assign res_row = row_act ? (new_row & cmask) : '0;
	assign res64   = lgs_pkg::OUT_BITS'(res_row);

	// write side: generation write-back of the row behind the window, or a toggle
	always_comb begin
		if (gen_go_s1) begin
			we    = rd_row_s1 != '0;
			waddr = wr_idx[RA_W-1:0];
			wdata = (wr_idx < nr) ? rule_next : '0;
		end else begin
			we    = (state_q == lgs_pkg::ST_RD_DATA) && tog_hit;
			waddr = row_w[RA_W-1:0];
			wdata = new_row;
		end
	end

	assign out_load = (state_q == lgs_pkg::ST_OUT) && (!m_tvalid_q || m_tready);

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			lgs_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (in_mode == lgs_pkg::MODE_ADVANCE) ? lgs_pkg::ST_GEN
						: lgs_pkg::ST_RD;
				end
			end
			lgs_pkg::ST_GEN: begin
				if (gen_cnt_q == NR_W'(MAX_ROWS)) begin
					state_d = lgs_pkg::ST_GEN_END;
				end
			end
			lgs_pkg::ST_GEN_END: state_d = lgs_pkg::ST_RD;
			lgs_pkg::ST_RD:      state_d = lgs_pkg::ST_RD_DATA;
			lgs_pkg::ST_RD_DATA: state_d = lgs_pkg::ST_OUT;
			lgs_pkg::ST_OUT: begin
				if (out_load) begin
					state_d = lgs_pkg::ST_IDLE;
				end
			end
			default: state_d = lgs_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lgs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q     <= lgs_pkg::ROWS_RESET;
			cols_q     <= lgs_pkg::COLS_RESET;
			valid_q    <= '0;
			gen_go_s1  <= 1'b0;
			rd_ok_s1   <= 1'b0;
			m_tvalid_q <= 1'b0;
			gen_cnt_q  <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lgs_pkg::REG_ROWS) begin
					rows_q <= cfg_data[lgs_pkg::NRI_W-1:0];
				end else if (cfg_index == lgs_pkg::REG_COLS) begin
					cols_q <= cfg_data;
				end
			end

			if (s_acc && (in_mode == lgs_pkg::MODE_CLEAR)) begin
				valid_q <= '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end

			if (s_acc) begin
				gen_cnt_q <= '0;
			end else if (state_q == lgs_pkg::ST_GEN) begin
				gen_cnt_q <= gen_cnt_q + NR_W'(1);
			end

			gen_go_s1 <= state_q == lgs_pkg::ST_GEN;
			rd_ok_s1  <= issue_live && valid_q[raddr];

			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_acc) begin
			mode_q  <= in_mode;
			row_q   <= s_tdata[6:2];
			col_q   <= s_tdata[12:7];
			above_q <= '0;
			here_q  <= '0;
		end else if (gen_go_s1) begin
			above_q <= here_q;
			here_q  <= gen_view;
		end
		rd_row_s1 <= gen_cnt_q;
		if (state_q == lgs_pkg::ST_RD_DATA) begin
			pend_bits_q <= res_row;
			pend_cell_q <= res64[col_q];
		end
		if (out_load) begin
			out_bits_q <= lgs_pkg::OUT_BITS'(pend_bits_q);
			out_cell_q <= pend_cell_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(lgs_pkg::OUT_DW - lgs_pkg::OUT_BITS - 1)'(0), out_cell_q, out_bits_q};

endmodule

FILE: rtl/core/lgs_checker.sv
module lgs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic [lgs_pkg::IN_DW-1:0]    s_tdata,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [lgs_pkg::OUT_DW-1:0]   m_tdata
);

	logic [lgs_pkg::COL_W-1:0] col_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_seen_q <= '0;
		end else if (s_tvalid && s_tready) begin
			col_seen_q <= s_tdata[12:7];
		end
	end

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one request in flight: no accept right after an accept
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request accepted while busy");

	// a new result only comes at the end of a request's work
	a_out_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a request in flight");

	// cell bit agrees with the reported row at the requested column
	a_cell_match: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> m_tdata[lgs_pkg::OUT_BITS] == m_tdata[col_seen_q])
		else $error("cell bit does not match row bits");

	// padding above the cell bit stays zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[lgs_pkg::OUT_DW-1:lgs_pkg::OUT_BITS+1] == '0)
		else $error("result padding not zero");

endmodule

bind life_grid_generation_step_core lgs_checker u_lgs_checker (.*);

FILE: bench/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int MAX_R       = lgs_pkg::DEF_MAX_ROWS;
	localparam int MAX_C       = lgs_pkg::DEF_MAX_COLS;
	localparam int PHASES      = 9;
	localparam int PHASE_ITEMS = 83;
	localparam int SETTLE      = 48;
	localparam int LONG_HOLD   = 400;
	localparam int STUCK_LIMIT = 3000;
	localparam int PLAN_LEN    = 31;

	typedef struct packed {
		lgs_pkg::mode_t md;
		logic [4:0]     r;
		logic [5:0]     c;
		logic [63:0]    bits;
		logic           cell_bit;
	} row_report_t;

	// one directed step: either an area setting or a request with an optional fixed answer
	typedef struct packed {
		logic           is_cfg;
		logic [6:0]     set_rows;
		logic [6:0]     set_cols;
		lgs_pkg::mode_t md;
		logic [4:0]     r;
		logic [5:0]     c;
		logic           typed;
		logic [63:0]    bits;
		logic           cell_bit;
	} step_row_t;

	localparam logic [63:0] TOP1 = 64'h8000_0000_0000_0000;
	localparam logic [63:0] TOP2 = 64'hC000_0000_0000_0000;
	localparam logic [63:0] R19  = 64'h0000_0080_0000_0000;

	localparam step_row_t PLAN [PLAN_LEN] = '{
		// is_cfg, rows, cols, mode, row, col, typed, row_bits, cell
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_READ,    5'd0,  6'd0,  1'b1, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_READ,    5'd31, 6'd63, 1'b1, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd0,  6'd0,  1'b1, 64'h1, 1'b1},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd19, 6'd39, 1'b1, R19,   1'b1},
		// toggles just outside the default area are dropped
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd20, 6'd0,  1'b1, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd0,  6'd40, 1'b1, 64'h1, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd0,  6'd1,  1'b1, 64'h3, 1'b1},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd0,  6'd2,  1'b1, 64'h7, 1'b1},
		// blinker on the top edge
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_ADVANCE, 5'd1,  6'd1,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_ADVANCE, 5'd0,  6'd1,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_CLEAR,   5'd0,  6'd1,  1'b1, 64'h0, 1'b0},
		'{1'b1, 7'd32, 7'd64, lgs_pkg::MODE_READ,  5'd0,  6'd0,  1'b0, 64'h0, 1'b0},
		// still block in the far corner
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd31, 6'd63, 1'b1, TOP1,  1'b1},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd31, 6'd62, 1'b1, TOP2,  1'b1},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd30, 6'd63, 1'b1, TOP1,  1'b1},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd30, 6'd62, 1'b1, TOP2,  1'b1},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_ADVANCE, 5'd31, 6'd62, 1'b0, 64'h0, 1'b0},
		// oversized area saturates
		'{1'b1, 7'd127, 7'd127, lgs_pkg::MODE_READ, 5'd0, 6'd0,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_ADVANCE, 5'd30, 6'd63, 1'b0, 64'h0, 1'b0},
		// shrunk area keeps stored cells until a generation runs
		'{1'b1, 7'd2, 7'd2, lgs_pkg::MODE_READ,    5'd0,  6'd0,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_READ,    5'd31, 6'd63, 1'b1, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd1,  6'd1,  1'b1, 64'h2, 1'b1},
		'{1'b1, 7'd32, 7'd64, lgs_pkg::MODE_READ,  5'd0,  6'd0,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_READ,    5'd30, 6'd62, 1'b0, 64'h0, 1'b0},
		'{1'b1, 7'd2, 7'd2, lgs_pkg::MODE_READ,    5'd0,  6'd0,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_ADVANCE, 5'd1,  6'd1,  1'b0, 64'h0, 1'b0},
		'{1'b1, 7'd32, 7'd64, lgs_pkg::MODE_READ,  5'd0,  6'd0,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_READ,    5'd31, 6'd63, 1'b0, 64'h0, 1'b0},
		// no active area at all
		'{1'b1, 7'd0, 7'd0, lgs_pkg::MODE_READ,    5'd0,  6'd0,  1'b0, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_TOGGLE,  5'd0,  6'd0,  1'b1, 64'h0, 1'b0},
		'{1'b0, 7'd0, 7'd0, lgs_pkg::MODE_ADVANCE, 5'd0,  6'd0,  1'b1, 64'h0, 1'b0}
	};

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              s_tvalid  = 1'b0;
	logic                              s_tready;
	logic [lgs_pkg::IN_DW-1:0]         s_tdata   = '0;
	logic                              m_tvalid;
	logic                              m_tready  = 1'b0;
	logic [lgs_pkg::OUT_DW-1:0]        m_tdata;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [lgs_pkg::CFG_IW-1:0]        cfg_index = '0;
	logic [lgs_pkg::CFG_DW-1:0]        cfg_data  = '0;

	// board model and area settings
	logic [63:0]                board [MAX_R];
	logic [lgs_pkg::NRI_W-1:0]  rows_reg;
	logic [lgs_pkg::NC_W-1:0]   cols_reg;
	int                         area_rows;
	int                         area_cols;
	logic [63:0]                area_mask;

	row_report_t awaited_rows [$];
	int          n_bad = 0;
	int          stuck_cycles = 0;
	bit          src_gaps = 1'b1;
	bit          sink_quiet = 1'b0;
	bit          long_hold_req = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	life_grid_generation_step_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	function automatic void update_area();
		area_rows = (rows_reg > MAX_R) ? MAX_R : int'(rows_reg);
		area_cols = (cols_reg > MAX_C) ? MAX_C : int'(cols_reg);
		area_mask = (area_cols >= 64) ? '1 : (64'd1 << area_cols) - 64'd1;
	endfunction

	function automatic logic [63:0] visible_row(int r);
		if (r >= area_rows)
			return '0;
		return board[r] & area_mask;
	endfunction

	function automatic row_report_t step_board(lgs_pkg::mode_t md, logic [4:0] r,
			logic [5:0] c);
		logic [63:0] nxt [MAX_R];
		logic [63:0] up, mid, dn;
		int          cnt;
		row_report_t res;
		case (md)
			lgs_pkg::MODE_ADVANCE: begin
				for (int i = 0; i < MAX_R; i++) begin
					nxt[i] = '0;
					if (i < area_rows) begin
						up  = (i > 0) ? visible_row(i - 1) : '0;
						mid = visible_row(i);
						dn  = visible_row(i + 1);
						for (int k = 0; k < area_cols; k++) begin
							cnt = 0;
							for (int j = k - 1; j <= k + 1; j++) begin
								if (j >= 0 && j < area_cols) begin
									cnt += up[j] + dn[j];
									if (j != k)
										cnt += mid[j];
								end
							end
							if (cnt == lgs_pkg::NB_BIRTH
									|| (cnt == lgs_pkg::NB_SURVIVE && mid[k]))
								nxt[i][k] = 1'b1;
						end
					end
				end
				for (int i = 0; i < MAX_R; i++)
					board[i] = nxt[i];
			end
			lgs_pkg::MODE_TOGGLE: begin
				if (r < area_rows && c < area_cols)
					board[r][c] = ~board[r][c];
			end
			lgs_pkg::MODE_CLEAR: begin
				for (int i = 0; i < MAX_R; i++)
					board[i] = '0;
			end
			default: ;
		endcase
		res.md       = md;
		res.r        = r;
		res.c        = c;
		res.bits     = visible_row(r);
		res.cell_bit = res.bits[c];
		return res;
	endfunction

	// mostly near a window inside the area so patterns build up, now and then anywhere
	function automatic int pick_coord(int span, int base, int w, int full);
		int v;
		if (span == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, full - 1);
		if ($urandom_range(0, 2) != 0)
			v = base + $urandom_range(0, w - 1);
		else
			v = $urandom_range(0, span - 1);
		return (v >= span) ? span - 1 : v;
	endfunction

	task automatic send_req(lgs_pkg::mode_t md, logic [4:0] r, logic [5:0] c, logic typed,
			logic [63:0] fixed_bits, logic fixed_cell);
		row_report_t res;
		if (src_gaps && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {3'b000, c, r, md};
		do @(posedge clk); while (!s_tready);
		res = step_board(md, r, c);
		if (typed) begin
			res.bits     = fixed_bits;
			res.cell_bit = fixed_cell;
		end
		awaited_rows.push_back(res);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (awaited_rows.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_area(logic [6:0] rows_val, logic [6:0] cols_val);
		cfg_valid <= 1'b1;
		cfg_index <= lgs_pkg::REG_ROWS;
		cfg_data  <= rows_val;
		do @(posedge clk); while (!cfg_ready);
		rows_reg = rows_val[lgs_pkg::NRI_W-1:0];
		cfg_index <= lgs_pkg::REG_COLS;
		cfg_data  <= cols_val;
		do @(posedge clk); while (!cfg_ready);
		cols_reg = cols_val;
		cfg_valid <= 1'b0;
		update_area();
	endtask

	initial begin : sink
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				m_tready <= 1'b0;
			end else if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold_left = LONG_HOLD - 1;
				m_tready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (!sink_quiet && $urandom_range(0, 7) == 0) begin
				hold_left = $urandom_range(0, 17);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_out
		row_report_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_rows.size() == 0) begin
				n_bad++;
				if (n_bad <= 10)
					$display("result with no request pending: row_bits %h cell %b",
						m_tdata[63:0], m_tdata[64]);
			end else begin
				want = awaited_rows.pop_front();
				if (m_tdata[63:0] !== want.bits || m_tdata[64] !== want.cell_bit) begin
					n_bad++;
					if (n_bad <= 10)
						$display("mismatch mode %0d row %0d col %0d: row_bits exp %h got %h, cell exp %b got %b",
							want.md, want.r, want.c, want.bits, m_tdata[63:0],
							want.cell_bit, m_tdata[64]);
				end
			end
		end
	end

	// ends the run if no request, result or register write moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				stuck_cycles <= 0;
			else
				stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("no progress for %0d cycles", STUCK_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [6:0]     rows_val, cols_val;
		logic [4:0]     r;
		logic [5:0]     c;
		lgs_pkg::mode_t md;
		int             sel, win_r, win_c;
		for (int i = 0; i < MAX_R; i++)
			board[i] = '0;
		rows_reg = lgs_pkg::ROWS_RESET;
		cols_reg = lgs_pkg::COLS_RESET;
		update_area();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < PLAN_LEN; k++) begin
			if (PLAN[k].is_cfg) begin
				wait_drain();
				write_area(PLAN[k].set_rows, PLAN[k].set_cols);
			end else begin
				send_req(PLAN[k].md, PLAN[k].r, PLAN[k].c, PLAN[k].typed,
					PLAN[k].bits, PLAN[k].cell_bit);
			end
		end

		for (int p = 0; p < PHASES; p++) begin
			wait_drain();
			case (p)
				0, 8:    begin rows_val = 7'd32;  cols_val = 7'd64;  end
				1:       begin rows_val = 7'd127; cols_val = 7'd127; end
				2:       begin rows_val = 7'd1;   cols_val = 7'd1;   end
				3:       begin rows_val = 7'd3;   cols_val = 7'd3;   end
				4:       begin rows_val = 7'd0;   cols_val = 7'd40;  end
				5: begin
					rows_val = 7'($urandom_range(1, 32));
					cols_val = 7'($urandom_range(1, 64));
				end
				6: begin
					rows_val = 7'($urandom_range(0, 127));
					cols_val = 7'($urandom_range(0, 127));
				end
				default: begin rows_val = 7'd20; cols_val = 7'd40; end
			endcase
			write_area(rows_val, cols_val);
			win_r = (area_rows > 0) ? $urandom_range(0, area_rows - 1) : 0;
			win_c = (area_cols > 0) ? $urandom_range(0, area_cols - 1) : 0;
			// phase 5 keeps the input busy through the long output stall
			src_gaps   = (p != 2 && p != 5 && p != PHASES - 1);
			sink_quiet = (p == PHASES - 1);
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				sel = $urandom_range(0, 99);
				if (i < 25)
					md = (sel < 80) ? lgs_pkg::MODE_TOGGLE : lgs_pkg::MODE_READ;
				else if (sel < 25)
					md = lgs_pkg::MODE_ADVANCE;
				else if (sel < 60)
					md = lgs_pkg::MODE_TOGGLE;
				else if (sel < 96)
					md = lgs_pkg::MODE_READ;
				else
					md = lgs_pkg::MODE_CLEAR;
				r = 5'(pick_coord(area_rows, win_r, 6, MAX_R));
				c = 6'(pick_coord(area_cols, win_c, 8, MAX_C));
				if (p == 5 && i == 10)
					long_hold_req = 1'b1;
				send_req(md, r, c, 1'b0, '0, 1'b0);
			end
		end

		wait_drain();
		if (n_bad == 0 && awaited_rows.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

FILE: life_grid_generation_step_core.f
rtl/core/lgs_pkg.sv
rtl/core/lgs_ram.sv
rtl/core/lgs_rule.sv
rtl/core/life_grid_generation_step_core.sv
rtl/core/lgs_checker.sv
bench/tb.sv
